// File: hdl/csem_pkg.sv
package csem_pkg;

   localparam int WAIT_DEPTH = 16;
   localparam int IDX_W = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
   localparam int TOTAL_W = $clog2(WAIT_DEPTH + 1);
   localparam int COUNT_W = 16;
   localparam int ID_W = 15;
   localparam int OP_W = 2;
   localparam int STATUS_W = 3;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [OP_W-1:0] {
      OP_TRY  = 2'd0,
      OP_WAIT = 2'd1,
      OP_POST = 2'd2
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_GRANTED = 3'd0,
      ST_REFUSED = 3'd1,
      ST_QUEUED  = 3'd2,
      ST_FULL    = 3'd3,
      ST_WOKEN   = 3'd4,
      ST_POSTED  = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_READ,
      S_WAKE
   } fsm_type;

   typedef struct packed {
      logic capture;
      logic apply;
      logic walk_start;
      logic read_issue;
      logic wake_emit;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            has_waiters;
      logic            out_free;
      logic            walk_last;
   } sts_type;

endpackage

// File: hdl/csem_req_if.sv
interface csem_req_if;
   logic                          valid;
   logic                          ready;
   logic [csem_pkg::OP_W-1:0]     opcode;
   logic [csem_pkg::ID_W-1:0]     requester_id;

   modport source (output valid, output opcode, output requester_id, input ready);
   modport sink (input valid, input opcode, input requester_id, output ready);
endinterface

// File: hdl/csem_rsp_if.sv
interface csem_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [csem_pkg::STATUS_W-1:0] status;
   logic [csem_pkg::ID_W-1:0]     woken_id;
   logic [csem_pkg::COUNT_W-1:0]  count_now;
   logic                          last;

   modport source (output valid, output status, output woken_id, output count_now,
                   output last, input ready);
   modport sink (input valid, input status, input woken_id, input count_now,
                 input last, output ready);
endinterface

// File: hdl/csem_ctrl.sv
module csem_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  csem_pkg::sts_type sts,
   output csem_pkg::cmd_type cmd
);

   csem_pkg::fsm_type state_ff;
   csem_pkg::fsm_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= csem_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         csem_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = csem_pkg::S_EXEC;
            end
         end
         csem_pkg::S_EXEC: begin
            case (sts.op)
               csem_pkg::OP_TRY, csem_pkg::OP_WAIT: begin
                  if (sts.out_free) begin
                     cmd.apply = 1'b1;
                     state_in = csem_pkg::S_IDLE;
                  end
               end
               csem_pkg::OP_POST: begin
                  if (sts.has_waiters) begin
                     cmd.walk_start = 1'b1;
                     state_in = csem_pkg::S_READ;
                  end else if (sts.out_free) begin
                     cmd.apply = 1'b1;
                     state_in = csem_pkg::S_IDLE;
                  end
               end
               default: begin
                  state_in = csem_pkg::S_IDLE;
               end
            endcase
         end
         csem_pkg::S_READ: begin
            cmd.read_issue = 1'b1;
            state_in = csem_pkg::S_WAKE;
         end
         csem_pkg::S_WAKE: begin
            if (sts.out_free) begin
               cmd.wake_emit = 1'b1;
               state_in = sts.walk_last ? csem_pkg::S_IDLE : csem_pkg::S_READ;
            end
         end
         default: begin
            state_in = csem_pkg::S_IDLE;
         end
      endcase
   end

endmodule

// File: hdl/csem_dp.sv
module csem_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  csem_pkg::cmd_type               cmd,
   output csem_pkg::sts_type               sts,
   input  logic                            csr_write_enable,
   input  logic [csem_pkg::COUNT_W-1:0]    csr_write_data,
   input  logic [csem_pkg::OP_W-1:0]       req_opcode,
   input  logic [csem_pkg::ID_W-1:0]       req_requester_id,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [csem_pkg::STATUS_W-1:0]   rsp_status,
   output logic [csem_pkg::ID_W-1:0]       rsp_woken_id,
   output logic [csem_pkg::COUNT_W-1:0]    rsp_count_now,
   output logic                            rsp_last
);

   logic [csem_pkg::ID_W-1:0]     wait_mem [csem_pkg::WAIT_DEPTH];
   logic [csem_pkg::ID_W-1:0]     rd_data_ff;

   logic [csem_pkg::OP_W-1:0]     op_ff;
   logic [csem_pkg::ID_W-1:0]     id_ff;
   logic [csem_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic [csem_pkg::TOTAL_W-1:0]  total_ff, total_in;
   logic [csem_pkg::IDX_W-1:0]    idx_ff, idx_in;

   logic                          valid_ff, valid_in;
   logic [csem_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [csem_pkg::ID_W-1:0]     woken_ff, woken_in;
   logic [csem_pkg::COUNT_W-1:0]  count_now_ff, count_now_in;
   logic                          last_ff, last_in;

   logic                          mem_we;
   logic                          walk_last;
   logic [csem_pkg::COUNT_W-1:0]  count_inc;

   assign count_inc = (count_ff == csem_pkg::COUNT_MAX) ? count_ff
                                                        : count_ff + csem_pkg::COUNT_W'(1);
   assign walk_last = (csem_pkg::TOTAL_W'(idx_ff) + csem_pkg::TOTAL_W'(1)) == total_ff;

   assign sts.op = op_ff;
   assign sts.has_waiters = (total_ff != '0);
   assign sts.out_free = !valid_ff || rsp_ready;
   assign sts.walk_last = walk_last;

   always_comb begin
      count_in = count_ff;
      total_in = total_ff;
      idx_in = idx_ff;
      mem_we = 1'b0;
      valid_in = valid_ff && !rsp_ready;
      status_in = status_ff;
      woken_in = woken_ff;
      count_now_in = count_now_ff;
      last_in = last_ff;

      if (csr_write_enable) begin
         count_in = csr_write_data;
         total_in = '0;
      end

      if (cmd.apply) begin
         valid_in = 1'b1;
         woken_in = '0;
         last_in = 1'b1;
         case (op_ff)
            csem_pkg::OP_TRY: begin
               if (count_ff != '0) begin
                  count_in = count_ff - csem_pkg::COUNT_W'(1);
                  status_in = csem_pkg::ST_GRANTED;
               end else begin
                  status_in = csem_pkg::ST_REFUSED;
               end
            end
            csem_pkg::OP_WAIT: begin
               if (count_ff != '0) begin
                  count_in = count_ff - csem_pkg::COUNT_W'(1);
                  status_in = csem_pkg::ST_GRANTED;
               end else if (total_ff == csem_pkg::TOTAL_W'(csem_pkg::WAIT_DEPTH)) begin
                  status_in = csem_pkg::ST_FULL;
               end else begin
                  mem_we = 1'b1;
                  total_in = total_ff + csem_pkg::TOTAL_W'(1);
                  status_in = csem_pkg::ST_QUEUED;
               end
            end
            default: begin
               count_in = count_inc;
               status_in = csem_pkg::ST_POSTED;
            end
         endcase
         count_now_in = count_in;
      end

      if (cmd.walk_start) begin
         count_in = count_inc;
         idx_in = '0;
      end

      if (cmd.wake_emit) begin
         valid_in = 1'b1;
         status_in = csem_pkg::ST_WOKEN;
         woken_in = rd_data_ff;
         count_now_in = count_ff;
         last_in = walk_last;
         idx_in = idx_ff + csem_pkg::IDX_W'(1);
         if (walk_last) begin
            total_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         total_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         total_ff <= total_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      status_ff <= status_in;
      woken_ff <= woken_in;
      count_now_ff <= count_now_in;
      last_ff <= last_in;
      if (cmd.capture) begin
         op_ff <= req_opcode;
         id_ff <= req_requester_id;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         wait_mem[total_ff[csem_pkg::IDX_W-1:0]] <= id_ff;
      end
      if (cmd.read_issue) begin
         rd_data_ff <= wait_mem[idx_ff];
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_status = status_ff;
   assign rsp_woken_id = woken_ff;
   assign rsp_count_now = count_now_ff;
   assign rsp_last = last_ff;

endmodule

// File: hdl/counting_semaphore_wait_list_core.sv
// Counting semaphore with a wait list of up to WAIT_DEPTH requester ids.
// Requests arrive on req with an opcode (try, wait, post) and a requester id.
// Results leave on rsp with a status, a woken id, the count after the request
// and a last flag that marks the final result of each request.
// A try or a wait gives one result; a post gives one wake result per queued
// requester in arrival order, or a single posted result when none are queued.
// Opcode 3 is dropped and gives no result.
// The block handles one request at a time. A try, a wait or a post without
// waiters is accepted, executed once the result register is free, and its
// result is registered onto rsp; the next request is taken once it executes.
// A post with waiters reads then wakes each waiter in turn, via the one read port.
// The result register frees the input side: the next request is accepted
// while a result waits, and execution pauses only when a new result would
// overwrite one that the receiver has not yet taken.
// Writing csr_write_data loads the count and empties the wait list; the user
// must do it only while the block is idle, which the block does not enforce.
// Reset clears the count, empties the list and drops any pending result.
module counting_semaphore_wait_list_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_enable,
   input  logic [csem_pkg::COUNT_W-1:0] csr_write_data,
   csem_req_if.sink                     req,
   csem_rsp_if.source                   rsp
);

   csem_pkg::cmd_type cmd;
   csem_pkg::sts_type sts;
   logic              req_ready;

   assign req.ready = req_ready;

   csem_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   csem_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_opcode       (req.opcode),
      .req_requester_id (req.requester_id),
      .rsp_valid        (rsp.valid),
      .rsp_ready        (rsp.ready),
      .rsp_status       (rsp.status),
      .rsp_woken_id     (rsp.woken_id),
      .rsp_count_now    (rsp.count_now),
      .rsp_last         (rsp.last)
   );

   a_one_request: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req_ready) |=> !req_ready)
      else $error("A request was accepted while another was in progress.");

   a_apply_free: assert property (@(posedge clock) disable iff (reset)
      cmd.apply |-> sts.out_free)
      else $error("A result overwrote one that was not taken.");

   a_wake_free: assert property (@(posedge clock) disable iff (reset)
      cmd.wake_emit |-> sts.out_free)
      else $error("A wake result overwrote one that was not taken.");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.apply, cmd.walk_start, cmd.read_issue, cmd.wake_emit}))
      else $error("More than one datapath command was issued in a cycle.");

   a_wake_follows_read: assert property (@(posedge clock) disable iff (reset)
      cmd.wake_emit |-> sts.has_waiters)
      else $error("A wake was emitted with an empty wait list.");

endmodule
